@@ rtl/kpdc_pkg.sv @@
// Shared types and constants for the key press duration classifier.
`default_nettype none

package kpdc_pkg;

    // Default width of the hold tick counter
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Threshold register width and reset values
    localparam int unsigned THR_WIDTH       = 16;
    localparam logic [THR_WIDTH-1:0] LONG_TICKS_RST      = 16'd200;
    localparam logic [THR_WIDTH-1:0] VERY_LONG_TICKS_RST = 16'd1000;

    // Margin added when the count is pinned past a threshold
    localparam int unsigned PIN_MARGIN = 50;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_WIDTH = 1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_TICKS      = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_VERY_LONG_TICKS = 1'b1;

    // Stream data widths
    localparam int unsigned S_TDATA_WIDTH = 8;
    localparam int unsigned M_TDATA_WIDTH = 8;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PRESS = 3'b010,
        PH_HOLD  = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_VLONG = 2'd3
    } key_event_t;

    // Classifier state seen from outside the core
    typedef struct packed {
        phase_t phase;
        logic   lock_armed;
    } core_status_t;

endpackage : kpdc_pkg

`default_nettype wire

@@ rtl/kpdc_core.sv @@
// Press/hold state machine, saturating hold counter and event decode.
`default_nettype none

module kpdc_core #(
    parameter int unsigned COUNT_WIDTH = kpdc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic                           key_level,
    input  wire logic                           power_on,
    input  wire logic [kpdc_pkg::THR_WIDTH-1:0] long_ticks,
    input  wire logic [kpdc_pkg::THR_WIDTH-1:0] very_long_ticks,
    output kpdc_pkg::key_event_t                key_event,
    output kpdc_pkg::core_status_t              status
);

    // Working width: room for either operand plus one carry bit
    localparam int unsigned CW = ((COUNT_WIDTH > kpdc_pkg::THR_WIDTH) ?
                                  COUNT_WIDTH : kpdc_pkg::THR_WIDTH) + 1;
    localparam logic [CW-1:0] CNT_MAX    = CW'({COUNT_WIDTH{1'b1}});
    localparam logic [CW-1:0] MARGIN_EXT = CW'(kpdc_pkg::PIN_MARGIN);

    kpdc_pkg::phase_t         phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic                     lock_reg,  lock_next;

    logic [CW-1:0] cnt_ext, inc_raw, inc_sat, long_ext, vlong_ext;
    logic [CW-1:0] pin_long_raw, pin_long, pin_vlong_raw, pin_vlong;
    logic          pressed;

    assign pressed       = ~key_level;
    assign cnt_ext       = CW'(count_reg);
    assign long_ext      = CW'(long_ticks);
    assign vlong_ext     = CW'(very_long_ticks);
    assign inc_raw       = cnt_ext + CW'(1);
    assign inc_sat       = (inc_raw > CNT_MAX) ? CNT_MAX : inc_raw;
    assign pin_long_raw  = long_ext + MARGIN_EXT;
    assign pin_long      = (pin_long_raw > CNT_MAX) ? CNT_MAX : pin_long_raw;
    assign pin_vlong_raw = vlong_ext + MARGIN_EXT;
    assign pin_vlong     = (pin_vlong_raw > CNT_MAX) ? CNT_MAX : pin_vlong_raw;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        lock_next  = lock_reg;
        key_event  = kpdc_pkg::EV_NONE;
        unique case (phase_reg)
            kpdc_pkg::PH_PRESS: begin
                phase_next = pressed ? kpdc_pkg::PH_HOLD : kpdc_pkg::PH_IDLE;
                count_next = '0;
            end
            kpdc_pkg::PH_HOLD: begin
                if (!pressed) begin
                    phase_next = kpdc_pkg::PH_IDLE;
                    if (cnt_ext < long_ext) begin
                        key_event = kpdc_pkg::EV_SHORT;
                    end
                    count_next = '0;
                    lock_next  = 1'b0;
                end else begin
                    count_next = inc_sat[COUNT_WIDTH-1:0];
                    if (inc_sat >= long_ext) begin
                        if (inc_sat == long_ext) begin
                            key_event = kpdc_pkg::EV_LONG;
                            lock_next = lock_reg | power_on;
                        end
                        if (lock_next) begin
                            if (inc_sat == vlong_ext) begin
                                key_event = kpdc_pkg::EV_VLONG;
                            end
                            if (inc_sat >= vlong_ext) begin
                                count_next = pin_vlong[COUNT_WIDTH-1:0];
                            end
                        end else begin
                            count_next = pin_long[COUNT_WIDTH-1:0];
                        end
                    end
                end
            end
            default: begin
                phase_next = pressed ? kpdc_pkg::PH_PRESS : kpdc_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= kpdc_pkg::PH_IDLE;
            count_reg <= '0;
            lock_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            lock_reg  <= lock_next;
        end
    end

    assign status.phase      = phase_reg;
    assign status.lock_armed = lock_reg;

endmodule : kpdc_core

`default_nettype wire

@@ rtl/key_press_duration_classifier.sv @@
// Top level of the key press duration classifier: stream ports, config, pipeline.
`default_nettype none

// Key press duration classifier. Each request on the s_ side is one sample of
// the key pin (low means pressed) together with the system power flag; each
// sample yields exactly one response on the m_ side carrying a key event:
// none, short press, long press or very long press. A press is qualified over
// two pressed samples, then hold ticks are counted. Release before long_ticks
// gives a short press; reaching long_ticks gives a long press and, with power
// on, arms a lock so that reaching very_long_ticks later gives a very long
// press. The hold counter saturates and is pinned 50 ticks past the threshold
// that applies. Throughput is one sample per clock unless m_tready stalls the
// output; each sample goes through the input register, then through the state
// update into the output register. Thresholds are written through the cfg_ port
// and must only change while no request is in flight.

module key_press_duration_classifier #(
    parameter int unsigned COUNT_WIDTH = kpdc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [kpdc_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // [0] key_level, [1] power_on
    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [kpdc_pkg::M_TDATA_WIDTH-1:0]      m_tdata,  // [1:0] key_event
    // Configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [kpdc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [kpdc_pkg::THR_WIDTH-1:0]     cfg_data
);

    // Threshold registers
    logic [kpdc_pkg::THR_WIDTH-1:0] long_ticks_reg;
    logic [kpdc_pkg::THR_WIDTH-1:0] very_long_ticks_reg;

    // Input register stage
    logic in_valid_reg;
    logic key_level_reg;
    logic power_on_reg;

    // Output register stage
    logic       out_valid_reg;
    logic [1:0] key_event_reg;

    logic                   advance;
    kpdc_pkg::key_event_t   core_event;
    kpdc_pkg::core_status_t core_status;

    // Move a request into the output stage when that stage is free or draining
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_ticks_reg      <= kpdc_pkg::LONG_TICKS_RST;
            very_long_ticks_reg <= kpdc_pkg::VERY_LONG_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                kpdc_pkg::CFG_LONG_TICKS:      long_ticks_reg      <= cfg_data;
                kpdc_pkg::CFG_VERY_LONG_TICKS: very_long_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            key_level_reg <= s_tdata[0];
            power_on_reg  <= s_tdata[1];
        end
    end

    kpdc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .key_level       (key_level_reg),
        .power_on        (power_on_reg),
        .long_ticks      (long_ticks_reg),
        .very_long_ticks (very_long_ticks_reg),
        .key_event       (core_event),
        .status          (core_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            key_event_reg <= core_event;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(kpdc_pkg::M_TDATA_WIDTH-2){1'b0}}, key_event_reg};

`ifndef NO_ASSERTIONS
    // The lock lives only inside a hold; it is cleared by the release
    a_lock_only_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        core_status.lock_armed |-> (core_status.phase == kpdc_pkg::PH_HOLD))
        else $error("lock armed outside hold phase");

    // A very long event can only come out of an armed lock
    a_vlong_needs_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (core_event == kpdc_pkg::EV_VLONG)) |=> core_status.lock_armed)
        else $error("very long event without armed lock");

    // A short press ends the hold and drops any lock
    a_short_ends_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (core_event == kpdc_pkg::EV_SHORT)) |=>
            ((core_status.phase == kpdc_pkg::PH_IDLE) && !core_status.lock_armed))
        else $error("short press did not return to idle");

    // Input side stalls only when both stages are full and output is blocked
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule : key_press_duration_classifier

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the key press duration classifier.

module testbench;

    import kpdc_pkg::*;

    // Counter width the DUT is built with (its default)
    localparam int unsigned CW = COUNT_WIDTH_DEF;
    // Cycles without any handshake before the run is declared hung; the longest
    // legitimate quiet stretch is the deliberate result back-pressure (SQUEEZE_CYCLES)
    localparam int unsigned WATCH_LIMIT = 2000;
    localparam int unsigned SQUEEZE_CYCLES = 300;
    // Idle cycles after the last response, before config writes and at the end
    localparam int unsigned DRAIN_CYCLES = 10;

    // ------------------------------------------------------------------
    // Predicts the event for every accepted sample and checks the results
    // ------------------------------------------------------------------
    class key_event_ledger;
        logic [THR_WIDTH-1:0] long_thr;
        logic [THR_WIDTH-1:0] vlong_thr;
        phase_t               ph;
        logic [CW-1:0]        count;
        bit                   lock_set;
        key_event_t           due_events[$];
        int unsigned          fail_count;

        function new();
            long_thr   = LONG_TICKS_RST;
            vlong_thr  = VERY_LONG_TICKS_RST;
            ph         = PH_IDLE;
            count      = '0;
            lock_set   = 1'b0;
            fail_count = 0;
        endfunction

        function void set_threshold(logic [CFG_IDX_WIDTH-1:0] idx, logic [THR_WIDTH-1:0] v);
            if (idx == CFG_LONG_TICKS) long_thr = v;
            else vlong_thr = v;
        endfunction

        // saturate a one-bit-wider sum to the counter width
        function logic [CW-1:0] clip(logic [CW:0] v);
            return v[CW] ? {CW{1'b1}} : v[CW-1:0];
        endfunction

        function key_event_t classify_sample(bit key, bit pwr);
            bit          pressed;
            key_event_t  ev;
            logic [CW:0] wide;
            pressed = !key;
            ev      = EV_NONE;
            case (ph)
                PH_PRESS: begin
                    ph    = pressed ? PH_HOLD : PH_IDLE;
                    count = '0;
                end
                PH_HOLD: begin
                    if (!pressed) begin
                        ph = PH_IDLE;
                        if (count < long_thr) ev = EV_SHORT;
                        count    = '0;
                        lock_set = 1'b0;
                    end else begin
                        wide  = {1'b0, count};
                        count = clip(wide + 1'b1);
                        if (count >= long_thr) begin
                            if (count == long_thr) begin
                                ev = EV_LONG;
                                if (pwr) lock_set = 1'b1;
                            end
                            if (lock_set) begin
                                if (count == vlong_thr) ev = EV_VLONG;
                                if (count >= vlong_thr) begin
                                    wide  = (CW+1)'(vlong_thr);
                                    count = clip(wide + (CW+1)'(PIN_MARGIN));
                                end
                            end else begin
                                wide  = (CW+1)'(long_thr);
                                count = clip(wide + (CW+1)'(PIN_MARGIN));
                            end
                        end
                    end
                end
                default: begin
                    ph = pressed ? PH_PRESS : PH_IDLE;
                end
            endcase
            return ev;
        endfunction

        function void log_sample(logic [S_TDATA_WIDTH-1:0] tdata);
            due_events.push_back(classify_sample(tdata[0], tdata[1]));
        endfunction

        function void match_event(logic [M_TDATA_WIDTH-1:0] tdata);
            key_event_t want;
            if (due_events.size() == 0) begin
                $error("unexpected response: m_tdata %0h with nothing outstanding", tdata);
                fail_count++;
                return;
            end
            want = due_events.pop_front();
            if (tdata[1:0] !== want) begin
                $error("key_event: expected %0d, got %0d", want, tdata[1:0]);
                fail_count++;
            end
            if (tdata[M_TDATA_WIDTH-1:2] !== '0) begin
                $error("m_tdata padding: expected 0, got %0h", tdata[M_TDATA_WIDTH-1:2]);
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------
    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata;   // [0] key_level, [1] power_on, rest zero
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_WIDTH-1:0] m_tdata;   // [1:0] key_event, rest zero
    logic                     cfg_wr_en;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [THR_WIDTH-1:0]     cfg_data;

    key_press_duration_classifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_event_ledger ledger = new();

    // idle percentages for each side, changed by the sequencer between phases
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // one-off long receiver hold-off, asked for by the sequencer
    bit          squeeze_req  = 1'b0;
    bit          squeeze_done = 1'b0;
    int unsigned samples_sent = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off so that the
    // pipeline fills and s_tready drops while requests are still offered
    // ------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (squeeze_req && !squeeze_done) begin
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge aclk);
                squeeze_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // check every accepted response against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.match_event(m_tdata);
    end

    // watchdog: any handshake on either stream counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side tasks; each one is entered and left just after a falling edge
    // ------------------------------------------------------------------
    task automatic send_sample(bit key, bit pwr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_WIDTH-2){1'b0}}, pwr, key};
        do @(posedge aclk); while (!s_tready);
        ledger.log_sample({{(S_TDATA_WIDTH-2){1'b0}}, pwr, key});
        samples_sent++;
        @(negedge aclk);
    endtask

    // n pressed samples (power on with probability pwr_pct) and a release;
    // a hold count of n-2 is reached, the first two only qualify the press
    task automatic press_for(int unsigned n, int unsigned pwr_pct);
        repeat (n) send_sample(1'b0, $urandom_range(0, 99) < pwr_pct);
        send_sample(1'b1, $urandom_range(0, 1));
    endtask

    // wait until every response is back, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (ledger.due_events.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_thresholds(int unsigned lt, int unsigned vt);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LONG_TICKS;
        cfg_data  <= THR_WIDTH'(lt);
        @(negedge aclk);
        cfg_index <= CFG_VERY_LONG_TICKS;
        cfg_data  <= THR_WIDTH'(vt);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.set_threshold(CFG_LONG_TICKS, THR_WIDTH'(lt));
        ledger.set_threshold(CFG_VERY_LONG_TICKS, THR_WIDTH'(vt));
    endtask

    // Mostly well-formed presses whose lengths cluster around both
    // thresholds, with key bounce and random noise mixed in
    task automatic run_presses(int unsigned budget);
        int unsigned stop_at;
        int unsigned lt;
        int unsigned vt;
        int unsigned top;
        int unsigned pct;
        stop_at = samples_sent + budget;
        lt      = ledger.long_thr;
        vt      = ledger.vlong_thr;
        top     = ((lt > vt) ? lt : vt) + 2;
        while (samples_sent < stop_at) begin
            pct = 50 * $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 8))
                       send_sample($urandom_range(0, 1), $urandom_range(0, 1));
                1: press_for($urandom_range(0, 3), pct);           // bounce
                2, 3: press_for($urandom_range(2, lt + 1), pct);   // short press
                4, 5: press_for(lt + $urandom_range(0, 4), pct);   // around long
                6, 7: press_for(top - 2 + $urandom_range(0, 4), pct);
                default: press_for(top + $urandom_range(0, 60), pct);
            endcase
        end
        // sometimes leave the key held so the next setting starts mid-press
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, lt + 3)) send_sample(1'b0, $urandom_range(0, 1));
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    int unsigned phase_long[10]  = '{2, 5, 8, 3, 15, 25, 2, 0, 0, 0};
    int unsigned phase_vlong[10] = '{3, 5, 4, 20, 40, 12, 3, 0, 0, 0};

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset thresholds: idle, release while qualifying, short press
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        press_for(3, 0);

        // Lowest thresholds: long without lock (pinned, no event on release),
        // then long with power on arming the lock and a very long press
        write_thresholds(2, 3);
        press_for(5, 0);
        press_for(6, 100);
        // both thresholds on the same tick: very long replaces long
        write_thresholds(5, 5);
        press_for(8, 100);

        // Random phases; idle pattern changes every few settings, the last
        // settings are drawn at random
        for (int i = 0; i < 10; i++) begin
            if (i < 3) begin
                tx_idle_pct = 12;
                rx_idle_pct = 57;
            end else if (i < 6) begin
                tx_idle_pct = 57;
                rx_idle_pct = 12;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i >= 7) begin
                phase_long[i]  = $urandom_range(2, 40);
                phase_vlong[i] = $urandom_range(3, 60);
            end
            write_thresholds(phase_long[i], phase_vlong[i]);
            if (i == 6) squeeze_req = 1'b1;
            run_presses(100);
        end

        // Highest thresholds, no idling: presses stay far below both, so
        // every release after the write is a short press against the full-width compare
        send_sample(1'b1, 1'b0);
        write_thresholds(60000, 65000);
        press_for(7, 0);
        press_for(40, 100);

        settle();
        if (ledger.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
